### rtl/rfths_pkg.sv
// Shared types, codes and defaults for the ready FIFO / timer heap scheduler.
// No dependencies.
`default_nettype none
package rfths_pkg;
  localparam int READY_DEPTH_DEF = 64;
  localparam int TIMER_DEPTH_DEF = 64;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [1:0] ACT_POST = 2'd0;
  localparam logic [1:0] ACT_SLEEP = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;
  localparam logic [1:0] ACT_DISPATCH = 2'd3;

  localparam logic [2:0] ST_DISPATCHED = 3'd0;
  localparam logic [2:0] ST_ACCEPTED = 3'd1;
  localparam logic [2:0] ST_NULL = 3'd2;
  localparam logic [2:0] ST_READY_FULL = 3'd3;
  localparam logic [2:0] ST_TIMERS_FULL = 3'd4;
  localparam logic [2:0] ST_WAITING = 3'd5;
  localparam logic [2:0] ST_IDLE = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,     // wait for an input word
    S_DECODE,   // decide what the word does
    S_UP_RD,    // read parent during sift-up
    S_UP_CMP,   // compare/swap with parent
    S_DRAIN,    // check heap top for a due timer
    S_POP_RD,   // read last entry to move to the root
    S_DN_RD,    // read children during sift-down
    S_DN_CMP,   // compare/swap with smaller child
    S_FIFO_RD,  // read ready FIFO head
    S_RESULT    // hold the result word
  } state_t;

  typedef struct packed {
    logic load;        // capture input word
    logic decode;      // resolve post/sleep/advance and start inserts
    logic up_rd;
    logic up_cmp;
    logic pop_start;   // drain: push top handle, start pop
    logic pop_rd;
    logic dn_rd;
    logic dn_cmp;
    logic fifo_rd;
    logic out_valid;
  } ctrl_t;

  typedef struct packed {
    logic need_up;     // insert went into a nonempty heap
    logic need_drain;  // dispatch with empty FIFO
    logic go_fifo;     // dispatch with nonempty FIFO
    logic up_more;     // sift-up continues
    logic can_drain;   // top is due and FIFO has room
    logic pop_more;    // heap holds more than one entry after pop
    logic dn_more;     // sift-down continues
  } stat_t;
endpackage
`default_nettype wire

### rtl/ready_fifo_timer_heap_scheduler.sv
// Top level of the task-wakeup scheduler: controller plus datapath.
// Depends on rfths_pkg, rfths_ctrl, rfths_dp.
`default_nettype none
// One input word is taken at a time and answered by one result word; the next
// word is taken the cycle after the result is taken. Post, advance, a
// zero-delay sleep and any rejected word go from decode to the result; a timed
// sleep into a nonempty heap adds a read and a compare per parent compared
// in sift-up. A dispatch from a nonempty ready FIFO reads the FIFO head first.
// With an empty FIFO it moves each due timer by a pop read, plus a read and a
// compare per sift-down step, then reads the head if any moved; the sift loops
// use the single heap memory. No clearing pass after reset.
module ready_fifo_timer_heap_scheduler #(
  parameter int READY_DEPTH = rfths_pkg::READY_DEPTH_DEF,
  parameter int TIMER_DEPTH = rfths_pkg::TIMER_DEPTH_DEF,
  parameter int HANDLE_BITS = rfths_pkg::HANDLE_BITS_DEF,
  parameter int TIME_BITS   = rfths_pkg::TIME_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // action[1:0], handle[17:2], amount[41:18]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata   // out_handle, status, next_deadline,
                                     // ready_count, timer_count
);
  rfths_pkg::ctrl_t ctl;
  rfths_pkg::stat_t st;
  logic [15:0] out_handle;
  logic [2:0]  status;
  logic [31:0] next_deadline;
  logic [6:0]  ready_count, timer_count;

  rfths_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .out_ready(m_tready),
    .st, .ctl, .in_ready(s_tready)
  );

  rfths_dp #(
    .READY_DEPTH(READY_DEPTH), .TIMER_DEPTH(TIMER_DEPTH),
    .HANDLE_BITS(HANDLE_BITS), .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk, .rst, .ctl, .st,
    .action(s_tdata[1:0]), .handle(s_tdata[17:2]), .amount(s_tdata[41:18]),
    .out_handle, .status, .next_deadline, .ready_count, .timer_count
  );

  assign m_tvalid = ctl.out_valid;
  assign m_tdata  = {7'd0, timer_count, ready_count, next_deadline, status, out_handle};
endmodule
`default_nettype wire

### rtl/rfths_ctrl.sv
// Controller state machine of the scheduler.
// Depends on rfths_pkg.
`default_nettype none
module rfths_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             out_ready,
  input  rfths_pkg::stat_t      st,
  output rfths_pkg::ctrl_t      ctl,
  output logic                  in_ready
);
  rfths_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= rfths_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      rfths_pkg::S_IDLE: if (in_valid) state_next = rfths_pkg::S_DECODE;
      rfths_pkg::S_DECODE: begin
        if (st.need_up) state_next = rfths_pkg::S_UP_RD;
        else if (st.go_fifo) state_next = rfths_pkg::S_FIFO_RD;
        else if (st.need_drain) state_next = rfths_pkg::S_DRAIN;
        else state_next = rfths_pkg::S_RESULT;
      end
      rfths_pkg::S_UP_RD: state_next = rfths_pkg::S_UP_CMP;
      rfths_pkg::S_UP_CMP:
        state_next = st.up_more ? rfths_pkg::S_UP_RD : rfths_pkg::S_RESULT;
      rfths_pkg::S_DRAIN: begin
        if (st.can_drain) state_next = rfths_pkg::S_POP_RD;
        else if (st.go_fifo) state_next = rfths_pkg::S_FIFO_RD;
        else state_next = rfths_pkg::S_RESULT;
      end
      rfths_pkg::S_POP_RD:
        state_next = st.pop_more ? rfths_pkg::S_DN_RD : rfths_pkg::S_DRAIN;
      rfths_pkg::S_DN_RD: state_next = rfths_pkg::S_DN_CMP;
      rfths_pkg::S_DN_CMP:
        state_next = st.dn_more ? rfths_pkg::S_DN_RD : rfths_pkg::S_DRAIN;
      rfths_pkg::S_FIFO_RD: state_next = rfths_pkg::S_RESULT;
      rfths_pkg::S_RESULT: if (out_ready) state_next = rfths_pkg::S_IDLE;
      default: state_next = rfths_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    in_ready = 1'b0;
    case (state)
      rfths_pkg::S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      rfths_pkg::S_DECODE: ctl.decode = 1'b1;
      rfths_pkg::S_UP_RD: ctl.up_rd = 1'b1;
      rfths_pkg::S_UP_CMP: ctl.up_cmp = 1'b1;
      rfths_pkg::S_DRAIN: ctl.pop_start = st.can_drain;
      rfths_pkg::S_POP_RD: ctl.pop_rd = 1'b1;
      rfths_pkg::S_DN_RD: ctl.dn_rd = 1'b1;
      rfths_pkg::S_DN_CMP: ctl.dn_cmp = 1'b1;
      rfths_pkg::S_FIFO_RD: ctl.fifo_rd = 1'b1;
      rfths_pkg::S_RESULT: ctl.out_valid = 1'b1;
      default: ;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !ctl.out_valid) else $error("ready while result pending");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (ctl.out_valid && !out_ready) |=> ctl.out_valid) else $error("result dropped");
  a_load_decode: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> ctl.decode) else $error("load not followed by decode");
endmodule
`default_nettype wire

### rtl/rfths_dp.sv
// Datapath: ready FIFO memory, timer heap memory, time counter, result word.
// Depends on rfths_pkg.
`default_nettype none
module rfths_dp #(
  parameter int READY_DEPTH = rfths_pkg::READY_DEPTH_DEF,
  parameter int TIMER_DEPTH = rfths_pkg::TIMER_DEPTH_DEF,
  parameter int HANDLE_BITS = rfths_pkg::HANDLE_BITS_DEF,
  parameter int TIME_BITS   = rfths_pkg::TIME_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  rfths_pkg::ctrl_t        ctl,
  output rfths_pkg::stat_t        st,
  input  wire logic [1:0]         action,
  input  wire logic [15:0]        handle,
  input  wire logic [23:0]        amount,
  output logic [15:0]             out_handle,
  output logic [2:0]              status,
  output logic [31:0]             next_deadline,
  output logic [6:0]              ready_count,
  output logic [6:0]              timer_count
);
  localparam int RAW = $clog2(READY_DEPTH);
  localparam int TAW = $clog2(TIMER_DEPTH);
  localparam int RCW = $clog2(READY_DEPTH + 1);
  localparam int TCW = $clog2(TIMER_DEPTH + 1);
  localparam int EW  = TIME_BITS + HANDLE_BITS;
  localparam int DW  = (TIME_BITS < 32) ? TIME_BITS : 32;

  logic [HANDLE_BITS-1:0] ready_mem [READY_DEPTH];
  logic [EW-1:0]          heap_mem  [TIMER_DEPTH];

  logic [1:0]             act;
  logic [HANDLE_BITS-1:0] hnd;
  logic [23:0]            amt;
  logic [RAW-1:0]         rhead, rtail;
  logic [RCW-1:0]         rfill;
  logic [TCW-1:0]         hfill;
  logic [TIME_BITS-1:0]   now_ms;
  logic [2:0]             stat_r;
  logic [HANDLE_BITS-1:0] oh_r;
  logic [EW-1:0]          top;      // copy of heap root
  logic [EW-1:0]          cur;      // entry being sifted
  logic [TAW-1:0]         idx;      // its position
  logic [EW-1:0]          rd_a, rd_b;
  logic [TAW-1:0]         ia, ib;
  logic [HANDLE_BITS-1:0] rd_r;

  // Heap port addresses for the read states
  logic [TAW+1:0]         lch, rch;
  logic [TAW-1:0]         par;
  logic                   l_ok, r_ok;
  logic                   fire_push, fire_heap;
  logic [TIME_BITS-1:0]   dl;
  logic                   up_swap;
  logic                   s_right;

  // heap memory: two registered read ports, two write ports for swaps
  logic            hw_en;
  logic [TAW-1:0]  hw_a;
  logic [EW-1:0]   hw_d;
  logic            hw2_en;
  logic [TAW-1:0]  hw2_a;
  logic [EW-1:0]   hw2_d;

  assign par  = (idx - TAW'(1)) >> 1;
  assign lch  = {1'b0, idx, 1'b1};
  assign rch  = lch + (TAW+2)'(1);
  assign l_ok = lch < (TAW+2)'(hfill);
  assign r_ok = rch < (TAW+2)'(hfill);
  assign dl   = now_ms + TIME_BITS'(amt);
  assign up_swap = rd_a[EW-1 -: TIME_BITS] > cur[EW-1 -: TIME_BITS];

  assign fire_push = (hnd != '0) && ((act == rfths_pkg::ACT_POST) ||
                     (act == rfths_pkg::ACT_SLEEP && amt == '0));
  assign fire_heap = (hnd != '0) && (act == rfths_pkg::ACT_SLEEP) && (amt != '0);

  // status back to the controller
  always_comb begin
    st = '0;
    st.need_up    = fire_heap && (hfill < TCW'(TIMER_DEPTH)) && (hfill != '0);
    st.go_fifo    = (act == rfths_pkg::ACT_DISPATCH) && (rfill != '0);
    st.need_drain = (act == rfths_pkg::ACT_DISPATCH) && (rfill == '0);
    st.up_more    = up_swap && (par != '0);
    st.can_drain  = (hfill != '0) && (top[EW-1 -: TIME_BITS] <= now_ms) &&
                    (rfill < RCW'(READY_DEPTH));
    st.pop_more   = (hfill > TCW'(1));
    st.dn_more    = 1'b0;
    if (l_ok) begin
      if (rd_a[EW-1 -: TIME_BITS] < cur[EW-1 -: TIME_BITS]) st.dn_more = 1'b1;
      if (r_ok && rd_b[EW-1 -: TIME_BITS] < cur[EW-1 -: TIME_BITS]) st.dn_more = 1'b1;
    end
  end

  // the last entry is read while the root is popped
  always_comb begin
    ia = par;
    ib = TAW'(rch);
    if (ctl.dn_rd) ia = TAW'(lch);
    if (ctl.pop_start) ia = TAW'(hfill - TCW'(1));
  end

  always_ff @(posedge clk) begin
    rd_a <= heap_mem[ia];
    rd_b <= heap_mem[ib];
    if (hw_en) heap_mem[hw_a] <= hw_d;
    if (hw2_en) heap_mem[hw2_a] <= hw2_d;
  end

  always_comb begin
    s_right = r_ok && (rd_b[EW-1 -: TIME_BITS] <
              (rd_a[EW-1 -: TIME_BITS] < cur[EW-1 -: TIME_BITS] ?
               rd_a[EW-1 -: TIME_BITS] : cur[EW-1 -: TIME_BITS]));
    hw_en = 1'b0; hw_a = idx; hw_d = cur;
    hw2_en = 1'b0; hw2_a = idx; hw2_d = cur;
    if (ctl.decode && fire_heap && hfill < TCW'(TIMER_DEPTH)) begin
      hw_en = 1'b1; hw_a = TAW'(hfill); hw_d = {dl, hnd};
    end
    if (ctl.up_cmp && up_swap) begin
      hw_en = 1'b1; hw_a = idx; hw_d = rd_a;
      hw2_en = 1'b1; hw2_a = par; hw2_d = cur;
    end
    if (ctl.pop_rd) begin
      hw_en = 1'b1; hw_a = '0; hw_d = rd_a;
    end
    if (ctl.dn_cmp && st.dn_more) begin
      hw_en = 1'b1; hw_a = idx; hw_d = s_right ? rd_b : rd_a;
      hw2_en = 1'b1; hw2_a = s_right ? TAW'(rch) : TAW'(lch); hw2_d = cur;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= ready_mem[rhead];
    if (ctl.decode && fire_push && rfill < RCW'(READY_DEPTH))
      ready_mem[rtail] <= hnd;
    if (ctl.pop_start) ready_mem[rtail] <= top[HANDLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      act <= action;
      hnd <= HANDLE_BITS'(handle);
      amt <= amount;
    end
    if (ctl.decode) begin
      cur <= {dl, hnd};
      idx <= TAW'(hfill);
    end
    if (ctl.up_cmp && up_swap) begin
      idx <= par;
      if (par == '0) top <= cur;
    end
    if (ctl.pop_rd) begin
      cur <= rd_a;
      top <= rd_a;
      idx <= '0;
    end
    if (ctl.dn_cmp && st.dn_more) begin
      idx <= s_right ? TAW'(rch) : TAW'(lch);
      if (idx == '0) top <= s_right ? rd_b : rd_a;
    end
    if (ctl.decode && fire_heap && hfill == '0) top <= {dl, hnd};
    if (ctl.fifo_rd) oh_r <= rd_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rhead <= '0; rtail <= '0; rfill <= '0; hfill <= '0; now_ms <= '0;
      stat_r <= rfths_pkg::ST_ACCEPTED;
    end else begin
      if (ctl.decode) begin
        stat_r <= rfths_pkg::ST_ACCEPTED;
        if (act == rfths_pkg::ACT_ADVANCE) now_ms <= now_ms + TIME_BITS'(amt);
        else if (act == rfths_pkg::ACT_DISPATCH)
          stat_r <= rfths_pkg::ST_IDLE;
        else if (hnd == '0) stat_r <= rfths_pkg::ST_NULL;
        else if (fire_push) begin
          if (rfill < RCW'(READY_DEPTH)) begin
            rtail <= (rtail == RAW'(READY_DEPTH-1)) ? '0 : rtail + RAW'(1);
            rfill <= rfill + RCW'(1);
          end else stat_r <= rfths_pkg::ST_READY_FULL;
        end else if (hfill < TCW'(TIMER_DEPTH)) hfill <= hfill + TCW'(1);
        else stat_r <= rfths_pkg::ST_TIMERS_FULL;
      end
      if (ctl.pop_start) begin
        rtail <= (rtail == RAW'(READY_DEPTH-1)) ? '0 : rtail + RAW'(1);
        rfill <= rfill + RCW'(1);
        hfill <= hfill - TCW'(1);
      end
      if (ctl.fifo_rd) begin
        stat_r <= rfths_pkg::ST_DISPATCHED;
        rhead <= (rhead == RAW'(READY_DEPTH-1)) ? '0 : rhead + RAW'(1);
        rfill <= rfill - RCW'(1);
      end
    end
  end

  // result fields come straight from state that holds still in the result state;
  // an undispatched dispatch reports waiting or idle by the final heap fill
  assign out_handle    = (stat_r == rfths_pkg::ST_DISPATCHED) ? 16'(oh_r) : 16'd0;
  assign status        = (act == rfths_pkg::ACT_DISPATCH &&
                          stat_r != rfths_pkg::ST_DISPATCHED) ?
                         ((hfill != '0) ? rfths_pkg::ST_WAITING : rfths_pkg::ST_IDLE) :
                         stat_r;
  assign next_deadline = (hfill != '0) ? 32'(top[HANDLE_BITS +: DW]) : 32'd0;
  assign ready_count   = 7'(rfill);
  assign timer_count   = 7'(hfill);

  a_rfill: assert property (@(posedge clk) disable iff (rst)
    rfill <= RCW'(READY_DEPTH)) else $error("ready fill overflow");
  a_hfill: assert property (@(posedge clk) disable iff (rst)
    hfill <= TCW'(TIMER_DEPTH)) else $error("heap fill overflow");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    ctl.pop_start |-> (hfill != '0)) else $error("pop from empty heap");
endmodule
`default_nettype wire

### sim/tb_ready_fifo_timer_heap_scheduler.sv
// Testbench for ready_fifo_timer_heap_scheduler: drives post/sleep/advance/dispatch words
// and checks every result word against a behavioral scheduler model.
// Depends on rfths_pkg and the scheduler RTL.
`default_nettype none
class sched_scoreboard;
  logic [15:0] rdy_q[$];
  logic [31:0] tm_dl[64];
  logic [15:0] tm_h[64];
  int          tm_n;
  logic [31:0] now;
  logic [71:0] pending[$];
  int          errors;
  int          shown;

  function void clear();
    rdy_q.delete();
    pending.delete();
    tm_n = 0;
    now = '0;
    errors = 0;
    shown = 0;
  endfunction

  function void swap_ent(int a, int b);
    logic [31:0] d;
    logic [15:0] h;
    d = tm_dl[a]; h = tm_h[a];
    tm_dl[a] = tm_dl[b]; tm_h[a] = tm_h[b];
    tm_dl[b] = d; tm_h[b] = h;
  endfunction

  function logic [15:0] pop_timer();
    logic [15:0] h;
    int i, l, r, s;
    h = tm_h[0];
    tm_n--;
    tm_dl[0] = tm_dl[tm_n];
    tm_h[0] = tm_h[tm_n];
    i = 0;
    forever begin
      l = 2 * i + 1; r = l + 1; s = i;
      if (l < tm_n && tm_dl[l] < tm_dl[s]) s = l;
      if (r < tm_n && tm_dl[r] < tm_dl[s]) s = r;
      if (s == i) break;
      swap_ent(i, s);
      i = s;
    end
    return h;
  endfunction

  // note an accepted word and queue its expected result
  function void note_word(logic [1:0] act, logic [15:0] h, logic [23:0] amt);
    logic [15:0] oh;
    logic [2:0]  st;
    logic [31:0] nd;
    int i;
    oh = '0;
    st = rfths_pkg::ST_ACCEPTED;
    if (act == rfths_pkg::ACT_POST || act == rfths_pkg::ACT_SLEEP) begin
      if (h == 0) st = rfths_pkg::ST_NULL;
      else if (act == rfths_pkg::ACT_POST || amt == 0) begin
        if (rdy_q.size() >= 64) st = rfths_pkg::ST_READY_FULL;
        else rdy_q.push_back(h);
      end else if (tm_n >= 64) st = rfths_pkg::ST_TIMERS_FULL;
      else begin
        tm_dl[tm_n] = now + 32'(amt);
        tm_h[tm_n] = h;
        i = tm_n;
        tm_n++;
        while (i > 0 && tm_dl[(i - 1) / 2] > tm_dl[i]) begin
          swap_ent((i - 1) / 2, i);
          i = (i - 1) / 2;
        end
      end
    end else if (act == rfths_pkg::ACT_ADVANCE) begin
      now = now + 32'(amt);
    end else begin
      if (rdy_q.size() == 0)
        while (tm_n > 0 && tm_dl[0] <= now && rdy_q.size() < 64)
          rdy_q.push_back(pop_timer());
      if (rdy_q.size() > 0) begin
        oh = rdy_q.pop_front();
        st = rfths_pkg::ST_DISPATCHED;
      end else st = (tm_n > 0) ? rfths_pkg::ST_WAITING : rfths_pkg::ST_IDLE;
    end
    nd = (tm_n > 0) ? tm_dl[0] : 32'd0;
    pending.push_back(72'({7'(tm_n), 7'(rdy_q.size()), nd, st, oh}));
  endfunction

  function void check_result(logic [71:0] got);
    logic [71:0] exp_w;
    if (pending.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("unexpected result word %h", got);
      end
      return;
    end
    exp_w = pending.pop_front();
    if (got[64:0] !== exp_w[64:0]) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("mismatch: handle exp %0d got %0d, status exp %0d got %0d",
                 exp_w[15:0], got[15:0], exp_w[18:16], got[18:16]);
        $display("  deadline exp %0d got %0d, ready exp %0d got %0d",
                 exp_w[50:19], got[50:19], exp_w[57:51], got[57:51]);
        $display("  timers exp %0d got %0d", exp_w[64:58], got[64:58]);
      end
    end
  endfunction
endclass

module tb_ready_fifo_timer_heap_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [71:0] m_tdata;

  int send_idle;
  int recv_stall;
  int cycles = 0;
  sched_scoreboard sb;

  ready_fifo_timer_heap_scheduler u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);

  always @(negedge clk)
    m_tready <= !rst && ($urandom_range(99) >= recv_stall);

  // called at a falling edge; returns at the falling edge after acceptance
  task send_word(logic [1:0] act, logic [15:0] h, logic [23:0] amt);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= {6'd0, amt, h, act};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(act, h, amt);
    @(negedge clk);
  endtask

  task rand_word();
    int r;
    r = $urandom_range(99);
    if (r < 25)
      send_word(rfths_pkg::ACT_POST,
                $urandom_range(3) == 0 ? 16'd0 : 16'($urandom), '0);
    else if (r < 50)
      send_word(rfths_pkg::ACT_SLEEP, 16'($urandom_range(1, 65535)),
                $urandom_range(7) == 0 ? 24'd0 :
                ($urandom_range(9) == 0 ? 24'($urandom) : 24'($urandom_range(1, 200))));
    else if (r < 65)
      send_word(rfths_pkg::ACT_ADVANCE, 16'($urandom),
                $urandom_range(19) == 0 ? 24'($urandom) : 24'($urandom_range(0, 150)));
    else send_word(rfths_pkg::ACT_DISPATCH, 16'($urandom), 24'($urandom));
  endtask

  initial begin
    int k, p;
    sb = new();
    sb.clear();
    send_idle = 0;
    recv_stall = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: empty dispatch, null handles, extremes, full stores, time wrap
    send_word(rfths_pkg::ACT_DISPATCH, 16'hffff, 24'hffffff);
    send_word(rfths_pkg::ACT_POST, 16'd0, 24'd5);
    send_word(rfths_pkg::ACT_SLEEP, 16'd0, 24'd5);
    send_word(rfths_pkg::ACT_POST, 16'hffff, 24'hffffff);
    send_word(rfths_pkg::ACT_SLEEP, 16'h0001, 24'd0);
    send_word(rfths_pkg::ACT_SLEEP, 16'h8000, 24'hffffff);
    send_word(rfths_pkg::ACT_SLEEP, 16'h1234, 24'd10);
    send_word(rfths_pkg::ACT_SLEEP, 16'h4321, 24'd10);
    send_word(rfths_pkg::ACT_DISPATCH, 16'd0, 24'd0);
    send_word(rfths_pkg::ACT_DISPATCH, 16'd0, 24'd0);
    send_word(rfths_pkg::ACT_DISPATCH, 16'd0, 24'd0);
    send_word(rfths_pkg::ACT_ADVANCE, 16'hffff, 24'd10);
    send_word(rfths_pkg::ACT_DISPATCH, 16'd0, 24'd0);
    send_word(rfths_pkg::ACT_DISPATCH, 16'd0, 24'd0);
    send_word(rfths_pkg::ACT_ADVANCE, 16'd0, 24'hffffff);
    send_word(rfths_pkg::ACT_DISPATCH, 16'd0, 24'd0);
    for (k = 0; k < 65; k++) send_word(rfths_pkg::ACT_POST, 16'(k + 1), '0);
    send_word(rfths_pkg::ACT_SLEEP, 16'h00aa, 24'd0);
    for (k = 0; k < 65; k++)
      send_word(rfths_pkg::ACT_SLEEP, 16'(k + 100), 24'($urandom_range(1, 40)));
    send_word(rfths_pkg::ACT_ADVANCE, 16'd0, 24'd50);
    for (k = 0; k < 140; k++) send_word(rfths_pkg::ACT_DISPATCH, 16'd0, 24'd0);
    // walk time past the 32-bit wrap
    for (k = 0; k < 260; k++) send_word(rfths_pkg::ACT_ADVANCE, 16'd0, 24'hffffff);
    send_word(rfths_pkg::ACT_SLEEP, 16'h0055, 24'hffffff);
    send_word(rfths_pkg::ACT_DISPATCH, 16'd0, 24'd0);
    // random phases with different idle/stall pressure
    for (p = 0; p < 4; p++) begin
      send_idle = (p == 1 || p == 3) ? (p == 1 ? 58 : 24) : 0;
      recv_stall = (p == 2 || p == 3) ? (p == 2 ? 58 : 24) : 0;
      for (k = 0; k < 160; k++) rand_word();
    end
    s_tvalid <= 1'b0;
    send_idle = 0;
    recv_stall = 0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
